>>> hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/atu_pkg.sv
package atu_pkg;

    localparam int MAX_RUN     = 6;
    localparam int RUN_CNT_W   = 3;
    localparam int RUN_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [1:0] MODE_FONT   = 2'd0;
    localparam logic [1:0] MODE_ASCII  = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_INTL    = 2'd1;
    localparam logic [1:0] CFG_LISTING = 2'd2;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic       intl_set;
        logic       printed_listing;
    } t_cfg;

    // bytes[0] goes out first
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    count;
    } t_run;

    typedef struct packed {
        logic [RUN_IDX_W-1:0] idx;
        logic                 pop;
    } t_back_stat;

endpackage

>>> hdl/atascii_utf8_transcoder.sv
// channel | direction | handshake                | payload
// cfg     | in        | i_cfg_we                 | i_cfg_index, i_cfg_data
// in      | in        | i_in_valid / o_in_stall  | i_kind, i_in_byte
// out     | out       | o_out_valid / i_out_stall| o_out_byte, o_last_of_run
//
// an input transfer is taken whenever the queue is not full; its results go out one byte
// per cycle while i_out_stall is low; an input gives 0 to 6 result bytes (3 for a glyph)
// the byte-wide output register sets the rate; the first result byte is presented
// after it passes through the queue slot and then the output register
// synchronous active-low reset clears config, decode state, held lf and the queue
// o_in_stall rises only while the queue is full; an output stall can fill the queue and so raise it
`include "assert_macros.svh"

module atascii_utf8_transcoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    atu_pkg::t_cfg        r_cfg;
    atu_pkg::t_run        run, head;
    atu_pkg::t_back_stat  stat;
    logic                 take, push, full, head_valid;
    logic [atu_pkg::QCNT_W-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                atu_pkg::CFG_MODE:    r_cfg.mode            <= i_cfg_data;
                atu_pkg::CFG_INTL:    r_cfg.intl_set        <= i_cfg_data[0];
                atu_pkg::CFG_LISTING: r_cfg.printed_listing <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = full;
    assign take       = i_in_valid && !full;

    atu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_take    (take),
        .i_kind    (i_kind),
        .i_in_byte (i_in_byte),
        .o_push    (push),
        .o_run     (run)
    );

    atu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_run        (run),
        .i_pop        (stat.pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .o_count      (q_count)
    );

    atu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_stat        (stat)
    );

    `ASSERT_ALWAYS(a_q_bound, i_clk, i_rst_n, q_count <= atu_pkg::QCNT_W'(atu_pkg::QUEUE_DEPTH))
    `ASSERT_IMPLY(a_head_count, i_clk, i_rst_n, head_valid, head.count != '0 && head.count <= 3'd6)
    `ASSERT_IMPLY(a_idx_in_run, i_clk, i_rst_n, head_valid, stat.idx < head.count)
    `ASSERT_IMPLY(a_pop_has_head, i_clk, i_rst_n, stat.pop, head_valid)
    `ASSERT_IMPLY(a_idle_idx, i_clk, i_rst_n, !head_valid, stat.idx == '0)

endmodule

>>> hdl/atu_front.sv
module atu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atu_pkg::t_cfg     i_cfg,
    input  logic              i_take,
    input  logic              i_kind,
    input  logic [7:0]        i_in_byte,
    output logic              o_push,
    output atu_pkg::t_run     o_run
);

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_LEAD  = 2'd1,
        PH_CONT  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      n;
    } t_piece;

    localparam logic [7:0] LF       = 8'h0A;
    localparam logic [7:0] EOL      = 8'h9B;
    localparam logic [7:0] LEAD     = 8'hEE;

    t_phase     r_phase, n_phase;
    logic [1:0] r_lead, n_lead;
    logic       r_held, n_held;

    t_piece          pre, body;
    logic [7:0]      c;
    atu_pkg::t_run   run;

    function automatic t_piece f_glyph(input logic [7:0] x, input logic intl);
        t_piece p;
        p.b[0] = LEAD;
        p.b[1] = {2'b10, 3'b000, intl, x[7], x[6]};
        p.b[2] = {2'b10, x[5:0]};
        p.n    = 2'd3;
        return p;
    endfunction

    function automatic t_piece f_one(input logic [7:0] x);
        t_piece p;
        p      = '0;
        p.b[0] = x;
        p.n    = 2'd1;
        return p;
    endfunction

    function automatic logic [7:0] f_to_atascii(input logic [7:0] x);
        return (x == LF) ? EOL : x;
    endfunction

    function automatic t_piece f_encode(input logic [7:0] x, input logic [1:0] mode,
                                        input logic intl);
        t_piece p;
        if (mode == atu_pkg::MODE_ASCII) begin
            if (x < 8'h20)       p = f_one(x + 8'h60);
            else if (x >= 8'hC0) p = f_one(x - 8'h80);
            else if (x == EOL)   p = f_one(LF);
            else                 p = f_one(x);
        end else begin
            if (x == EOL)
                p = f_one(LF);
            else if (x[6:0] <= 7'h1F || x[6:0] == 7'h60 || x >= 8'h7B)
                p = f_glyph(x, intl);
            else
                p = f_one(x);
        end
        return p;
    endfunction

    assign c = i_in_byte;

    always_comb begin
        n_phase = r_phase;
        n_lead  = r_lead;
        n_held  = r_held;
        pre     = '0;
        body    = '0;
        if (i_kind == atu_pkg::KIND_FLUSH) begin
            if (r_held) pre = f_one(LF);
            n_held  = 1'b0;
            n_phase = PH_PLAIN;
            n_lead  = 2'd0;
        end else if (i_cfg.mode == atu_pkg::MODE_DECODE) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (c[7:6] == 2'b10) begin
                        n_lead  = c[1:0];
                        n_phase = PH_CONT;
                    end else begin
                        body.b[0] = LEAD;
                        body.b[1] = f_to_atascii(c);
                        body.n    = 2'd2;
                        n_phase   = PH_PLAIN;
                    end
                end
                PH_CONT: begin
                    body    = f_one({r_lead, c[5:0]});
                    n_phase = PH_PLAIN;
                end
                default: begin
                    if (c == LEAD) n_phase = PH_LEAD;
                    else           body = f_one(f_to_atascii(c));
                end
            endcase
        end else begin
            // printed listing: a held lf is resolved by the byte after it
            if (i_cfg.printed_listing && r_held) begin
                if (c >= 8'h30 && c <= 8'h39) pre = f_one(LF);
                else                          pre = f_glyph(LF, i_cfg.intl_set);
            end
            if (i_cfg.printed_listing && c == LF) begin
                n_held = 1'b1;
            end else begin
                if (i_cfg.printed_listing) n_held = 1'b0;
                body = f_encode(c, i_cfg.mode, i_cfg.intl_set);
            end
        end
    end

    always_comb begin
        run = '0;
        run.bytes[2:0] = pre.b;
        priority case (pre.n)
            2'd0:    run.bytes[2:0] = body.b;
            2'd1:    run.bytes[3:1] = body.b;
            default: run.bytes[5:3] = body.b;
        endcase
        run.count = {1'b0, pre.n} + {1'b0, body.n};
    end

    assign o_run  = run;
    assign o_push = i_take && (run.count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_lead  <= 2'd0;
            r_held  <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_lead  <= n_lead;
            r_held  <= n_held;
        end
    end

endmodule

>>> hdl/atu_queue.sv
module atu_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  atu_pkg::t_run               i_run,
    input  logic                        i_pop,
    output logic                        o_full,
    output logic                        o_head_valid,
    output atu_pkg::t_run               o_head,
    output logic [atu_pkg::QCNT_W-1:0]  o_count
);

    atu_pkg::t_run r_slot [atu_pkg::QUEUE_DEPTH];
    logic [atu_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [atu_pkg::QCNT_W-1:0] r_cnt;

    assign o_full       = (r_cnt == atu_pkg::QCNT_W'(atu_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_slot[r_rd];
    assign o_count      = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr] <= i_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + atu_pkg::QCNT_W'(i_push) - atu_pkg::QCNT_W'(i_pop);
        end
    end

endmodule

>>> hdl/atu_back.sv
module atu_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_head_valid,
    input  atu_pkg::t_run         i_head,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_of_run,
    output atu_pkg::t_back_stat   o_stat
);

    logic [atu_pkg::RUN_IDX_W-1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       step, last;

    // one byte of the head run moves into the output register per cycle unless a held output byte is stalled
    assign step = i_head_valid && (!r_out_valid || !i_out_stall);
    assign last = (r_idx == i_head.count - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) r_idx <= last ? '0 : r_idx + 1'b1;
            if (step)              r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte <= i_head.bytes[r_idx];
            r_out_last <= last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_stat.idx    = r_idx;
    assign o_stat.pop    = step && last;

endmodule
